// ----- rtl/core/assert_macros.svh -----
// Assertion helper macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication check that is gated off while reset is held.
`define SFN_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication check that is gated off while reset is held.
`define SFN_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- rtl/core/sfn_pkg.sv -----
// ----------------------------------------------------------------------------
// sfn_pkg
// Shared types and constants for the spatial focus navigator.
// ----------------------------------------------------------------------------
package sfn_pkg;
  localparam int DEPTH_DEF = 64;

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_ADD   = 2'd1;
  localparam logic [1:0] REQ_NAV   = 2'd2;
  localparam logic [1:0] REQ_RSVD  = 2'd3;  // no operation, plain ok result

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_NONE  = 2'd3;

  localparam logic [2:0] DIR_NEXT  = 3'd0;
  localparam logic [2:0] DIR_PREV  = 3'd1;
  localparam logic [2:0] DIR_UP    = 3'd2;
  localparam logic [2:0] DIR_DOWN  = 3'd3;
  localparam logic [2:0] DIR_LEFT  = 3'd4;
  localparam logic [2:0] DIR_RIGHT = 3'd5;

  // One stored point.
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic        [15:0] tag;
  } point_t;

  // Control from the sequencer to every cell of the row.
  typedef struct packed {
    logic shift_left;   // rotate toward index 0
    logic write_ins;    // insert slot loads, slots past it take left neighbor
  } cell_ctl_t;
endpackage

// ----- rtl/core/sfn_if.sv -----
// ----------------------------------------------------------------------------
// sfn_req_if / sfn_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface sfn_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [15:0] point_x;
  logic signed [15:0] point_y;
  logic [15:0]        point_tag;
  logic [2:0]         direction;
  modport source (output valid, req_type, point_x, point_y, point_tag, direction,
                  input ready);
  modport sink (input valid, req_type, point_x, point_y, point_tag, direction,
                output ready);
endinterface

interface sfn_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [15:0] target_x;
  logic signed [15:0] target_y;
  logic [15:0]        target_tag;
  logic [5:0]         target_index;
  logic [6:0]         point_count;
  modport source (output valid, status, target_x, target_y, target_tag,
                  target_index, point_count, input ready);
  modport sink (input valid, status, target_x, target_y, target_tag,
                target_index, point_count, output ready);
endinterface

// ----- rtl/core/sfn_cell.sv -----
// ----------------------------------------------------------------------------
// sfn_cell
// One slot of the point row: holds a point and passes it to a neighbor.
// ----------------------------------------------------------------------------
module sfn_cell (
  input  logic              clk,
  input  sfn_pkg::cell_ctl_t ctl,
  input  logic              at_ins,     // this slot is the insert position
  input  logic              after_ins,  // this slot is past the insert position
  input  sfn_pkg::point_t   ins_pt,
  input  sfn_pkg::point_t   from_left,  // slot index-1
  input  sfn_pkg::point_t   from_right, // slot index+1 (or wrap)
  output sfn_pkg::point_t   pt
);
  sfn_pkg::point_t pt_r, pt_nxt;

  // Shift for insert, or rotate the whole row by one
  always_comb begin
    pt_nxt = pt_r;
    if (ctl.shift_left) begin
      pt_nxt = from_right;
    end else if (ctl.write_ins && at_ins) begin
      pt_nxt = ins_pt;
    end else if (ctl.write_ins && after_ins) begin
      pt_nxt = from_left;
    end
  end

  always_ff @(posedge clk) begin
    pt_r <= pt_nxt;
  end

  assign pt = pt_r;
endmodule

// ----- rtl/core/spatial_focus_navigator_core.sv -----
// ----------------------------------------------------------------------------
// spatial_focus_navigator_core
// Sorted focus-point table with nearest-point and neighbor navigation.
// ----------------------------------------------------------------------------
// Points live in a row of DEPTH cells that can rotate by one slot per cycle,
// so slot 0 always presents the next point to a single scan unit. Every pass
// rotates the row all the way round, so it is back in sorted order when the
// pass ends. A clear, an unknown request, an add to a full table or a
// navigate on an empty table goes straight to the result. An add makes a
// pass to find the insert position (none on an empty table), then writes it
// while the tail shifts, then raises the result. A navigate makes one pass
// for the nearest point, one to locate its row and neighbors, one to pick
// the closest in the adjacent row, and one to fetch the chosen point when
// there is one. A new request is taken once the result has transferred and
// the sequencer is back in idle.
module spatial_focus_navigator_core #(
  parameter int DEPTH = sfn_pkg::DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  sfn_req_if.sink   in_req,
  sfn_rsp_if.source out_rsp
);
  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_FIND = 7'b0000010,   // add: locate insert position
    S_INS  = 7'b0000100,   // add: write and shift
    S_NEAR = 7'b0001000,   // nav: nearest point pass
    S_NBR  = 7'b0010000,   // nav: row pass around hit
    S_ROW  = 7'b0100000,   // nav: pick in adjacent row
    S_OUT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // Row of cells
  sfn_pkg::point_t   pts [DEPTH];
  sfn_pkg::cell_ctl_t ctl;
  sfn_pkg::point_t   ins_pt_r;
  logic [IW-1:0]     ins_pos_r;
  logic [CW-1:0]     count_r;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    localparam int GL = (g == 0) ? 0 : g - 1;
    localparam int GR = (g == DEPTH - 1) ? 0 : g + 1;
    sfn_pkg::point_t right_in;
    // rotate: last valid slot wraps to slot 0 content
    assign right_in = (CW'(g) == count_r - CW'(1)) ? pts[0] : pts[GR];
    sfn_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .at_ins    (ins_pos_r == IW'(g)),
      .after_ins (IW'(g) > ins_pos_r),
      .ins_pt    (ins_pt_r),
      .from_left (pts[GL]),
      .from_right(right_in),
      .pt        (pts[g])
    );
  end

  // Request registers
  logic [1:0]         req_r;
  logic [2:0]         dir_r;
  logic signed [15:0] qx_r, qy_r;

  // Scan state
  logic [CW-1:0] k_r;           // scan step; slot 0 holds point k_r
  logic [33:0]   bestd_r;
  logic [IW-1:0] best_r;
  logic signed [15:0] hx_r, hy_r; // hit point
  logic          have_prev_r, have_next_r, have_up_r, have_down_r;
  logic [IW-1:0] prev_i_r, next_i_r;
  logic signed [15:0] up_y_r, down_y_r;
  logic [IW-1:0] up_i_r, down_i_r;
  logic [16:0]   up_d_r, down_d_r;
  logic          row_seen_r;    // seen a point of the row above the hit
  logic          in_down_r;     // seen a point of the row below the hit

  // Result registers
  logic          ov_r;
  logic [1:0]    o_st_r;
  sfn_pkg::point_t o_pt_r;
  logic [IW-1:0] o_idx_r;
  logic          o_have_r;
  logic          pend_r;        // result fields must be fetched from row

  sfn_pkg::point_t cur;
  assign cur = pts[0];

  // Squared distance of slot 0 to the query, one multiplier per axis
  logic [16:0] ax, ay, hdx;
  logic [33:0] dd;
  always_comb begin
    ax = (cur.x >= qx_r) ? 17'(cur.x - qx_r) : 17'(qx_r - cur.x);
    ay = (cur.y >= qy_r) ? 17'(cur.y - qy_r) : 17'(qy_r - cur.y);
    hdx = (cur.x >= hx_r) ? 17'(cur.x - hx_r) : 17'(hx_r - cur.x);
  end
  logic [33:0] sqx, sqy;
  assign sqx = 34'(ax) * 34'(ax);
  assign sqy = 34'(ay) * 34'(ay);
  assign dd  = sqx + sqy;

  logic [IW-1:0] ki;
  assign ki = k_r[IW-1:0];
  logic last;
  assign last = (k_r == count_r - CW'(1));

  logic in_acc, out_acc;
  assign in_req.ready = (state_r == S_IDLE) && !ov_r;
  assign in_acc  = in_req.valid && in_req.ready;
  assign out_acc = out_rsp.valid && out_rsp.ready;

  always_comb begin
    ctl = '0;
    if (state_r == S_FIND || state_r == S_NEAR || state_r == S_NBR
        || state_r == S_ROW || (state_r == S_OUT && pend_r)) begin
      ctl.shift_left = (count_r != '0);
    end
    if (state_r == S_INS) ctl.write_ins = 1'b1;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc) begin
        case (in_req.req_type)
          sfn_pkg::REQ_ADD:
            state_nxt = (count_r >= CW'(DEPTH)) ? S_OUT
                      : (count_r == '0) ? S_INS : S_FIND;
          sfn_pkg::REQ_NAV: state_nxt = (count_r == '0) ? S_OUT : S_NEAR;
          default: state_nxt = S_OUT;
        endcase
      end
      S_FIND:  if (last) state_nxt = S_INS;
      S_INS:   state_nxt = S_OUT;
      S_NEAR:  if (last) state_nxt = S_NBR;
      S_NBR:   if (last) state_nxt = S_ROW;
      S_ROW:   if (last) state_nxt = S_OUT;
      S_OUT:   if (!pend_r) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  logic row_eq, find_lt;
  assign row_eq  = (cur.y == hy_r);
  assign find_lt = (cur.y < qy_r) || (cur.y == qy_r && cur.x <= qx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_acc) ov_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_acc) begin
          req_r  <= in_req.req_type;
          dir_r  <= in_req.direction;
          qx_r   <= in_req.point_x;
          qy_r   <= in_req.point_y;
          ins_pt_r <= '{x: in_req.point_x, y: in_req.point_y, tag: in_req.point_tag};
          k_r <= '0;
          ins_pos_r <= '0;
          o_have_r <= 1'b0;
          o_st_r <= sfn_pkg::ST_OK;
          pend_r <= 1'b0;
          case (in_req.req_type)
            sfn_pkg::REQ_CLEAR: count_r <= '0;
            sfn_pkg::REQ_ADD:
              if (count_r >= CW'(DEPTH)) o_st_r <= sfn_pkg::ST_FULL;
            sfn_pkg::REQ_NAV:
              if (count_r == '0) o_st_r <= sfn_pkg::ST_EMPTY;
            default: ;
          endcase
        end
        S_FIND: begin
          if (find_lt) ins_pos_r <= IW'(k_r + CW'(1));
          k_r <= last ? '0 : k_r + CW'(1);
        end
        S_INS: begin
          count_r <= count_r + CW'(1);
          o_have_r <= 1'b1;
          o_pt_r  <= ins_pt_r;
          o_idx_r <= ins_pos_r;
        end
        S_NEAR: begin
          if (k_r == '0 || dd < bestd_r) begin
            bestd_r <= dd;
            best_r  <= ki;
            hx_r    <= cur.x;
            hy_r    <= cur.y;
          end
          k_r <= last ? '0 : k_r + CW'(1);
          have_prev_r <= 1'b0; have_next_r <= 1'b0;
          have_up_r <= 1'b0;   have_down_r <= 1'b0;
          row_seen_r <= 1'b0;
        end
        S_NBR: begin
          // points before hit: last row above; after hit: first row below
          if (CW'(ki) + CW'(1) == CW'(best_r)) begin
            prev_i_r <= ki;
            have_prev_r <= row_eq;
          end
          if (CW'(ki) == CW'(best_r) + CW'(1)) begin
            next_i_r <= ki;
            have_next_r <= row_eq;
          end
          if (cur.y < hy_r) begin
            have_up_r <= 1'b1;
            up_y_r <= cur.y;
          end
          if (cur.y > hy_r && !have_down_r) begin
            have_down_r <= 1'b1;
            down_y_r <= cur.y;
          end
          k_r <= last ? '0 : k_r + CW'(1);
          in_down_r <= 1'b0;
        end
        S_ROW: begin
          // up: ties go to larger index, so take <=; down: first strict min
          if (have_up_r && cur.y == up_y_r
              && (!row_seen_r || hdx <= up_d_r)) begin
            up_d_r <= hdx; up_i_r <= ki; row_seen_r <= 1'b1;
          end
          if (have_down_r && cur.y == down_y_r
              && (!in_down_r || hdx < down_d_r)) begin
            down_d_r <= hdx; down_i_r <= ki; in_down_r <= 1'b1;
          end
          k_r <= last ? '0 : k_r + CW'(1);
        end
        S_OUT: begin
          if (pend_r) begin
            // full rotation: grab the chosen point as it passes slot 0
            if (ki == o_idx_r) begin
              o_pt_r <= cur;
              o_have_r <= 1'b1;
            end
            if (last) begin
              pend_r <= 1'b0;
              ov_r <= 1'b1;
            end
            k_r <= last ? '0 : k_r + CW'(1);
          end else if (state_nxt == S_IDLE && !ov_r && !o_have_r
                       && o_st_r != sfn_pkg::ST_OK) begin
            ov_r <= 1'b1;
          end else if (!ov_r && req_r != sfn_pkg::REQ_NAV) begin
            ov_r <= 1'b1;
          end else if (!ov_r && o_st_r == sfn_pkg::ST_EMPTY) begin
            ov_r <= 1'b1;
          end
        end
        default: ;
      endcase
      // after the last row pass decide the target
      if (state_r == S_ROW && last) begin
        if (hx_r != qx_r || hy_r != qy_r) begin
          o_idx_r <= best_r; pend_r <= 1'b1;
        end else begin
          case (dir_r)
            sfn_pkg::DIR_NEXT: begin
              o_idx_r <= (CW'(best_r) + CW'(1) < count_r) ? best_r + IW'(1) : '0;
              pend_r <= 1'b1;
            end
            sfn_pkg::DIR_PREV: begin
              o_idx_r <= (best_r != '0) ? best_r - IW'(1) : IW'(count_r - CW'(1));
              pend_r <= 1'b1;
            end
            sfn_pkg::DIR_LEFT:
              if (have_prev_r) begin o_idx_r <= prev_i_r; pend_r <= 1'b1; end
              else o_st_r <= sfn_pkg::ST_NONE;
            sfn_pkg::DIR_RIGHT:
              if (have_next_r) begin o_idx_r <= next_i_r; pend_r <= 1'b1; end
              else o_st_r <= sfn_pkg::ST_NONE;
            sfn_pkg::DIR_UP: begin
              if (have_up_r && row_seen_r) begin
                o_idx_r <= up_i_r; pend_r <= 1'b1;
              end else if (have_up_r && cur.y == up_y_r) begin
                o_idx_r <= ki; pend_r <= 1'b1;
              end else o_st_r <= sfn_pkg::ST_NONE;
            end
            sfn_pkg::DIR_DOWN: begin
              if (have_down_r && in_down_r
                  && !(cur.y == down_y_r && hdx < down_d_r)) begin
                o_idx_r <= down_i_r; pend_r <= 1'b1;
              end else if (have_down_r && cur.y == down_y_r) begin
                o_idx_r <= ki; pend_r <= 1'b1;
              end else o_st_r <= sfn_pkg::ST_NONE;
            end
            default: o_st_r <= sfn_pkg::ST_NONE;
          endcase
        end
      end
    end
  end

  // The last point of the table can sit in the row below the hit, so the
  // down pick folds the compare for slot 0 into the final decision above.

  assign out_rsp.valid        = ov_r;
  assign out_rsp.status       = o_st_r;
  assign out_rsp.target_x     = o_have_r ? o_pt_r.x : '0;
  assign out_rsp.target_y     = o_have_r ? o_pt_r.y : '0;
  assign out_rsp.target_tag   = o_have_r ? o_pt_r.tag : '0;
  assign out_rsp.target_index = o_have_r ? 6'(o_idx_r) : '0;
  assign out_rsp.point_count  = 7'(count_r);
endmodule

// ----- rtl/core/sfn_checker.sv -----
// ----------------------------------------------------------------------------
// sfn_checker
// Port-level checks for the spatial focus navigator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module sfn_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [1:0] out_status,
  input logic [5:0] out_target_index,
  input logic [6:0] out_point_count
);
  // a pending result holds until its transfer
  `SFN_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  // no new request while a result is waiting
  `SFN_ASSERT_IMP(a_no_overlap, clk, rst_n, out_valid, !in_ready)
  // non-ok status carries a zero index
  `SFN_ASSERT_IMP(a_zero_idx, clk, rst_n, out_valid && out_status != sfn_pkg::ST_OK,
                  out_target_index == 6'd0)
  // empty status only with an empty table
  `SFN_ASSERT_IMP(a_empty, clk, rst_n, out_valid && out_status == sfn_pkg::ST_EMPTY,
                  out_point_count == 7'd0)
endmodule

bind spatial_focus_navigator_core sfn_checker u_sfn_checker (
  .clk(clk), .rst_n(rst_n),
  .in_ready(in_req.ready),
  .out_valid(out_rsp.valid), .out_ready(out_rsp.ready),
  .out_status(out_rsp.status), .out_target_index(out_rsp.target_index),
  .out_point_count(out_rsp.point_count)
);

// ----- bench/spatial_focus_navigator_checker.sv -----
// ----------------------------------------------------------------------------
// spatial_focus_navigator_checker
// Watches the request and result channels, keeps its own sorted point table,
// predicts one result per accepted request and compares it field by field.
// ----------------------------------------------------------------------------
module spatial_focus_navigator_checker #(
  parameter int DEPTH = sfn_pkg::DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  sfn_req_if   mon_req,
  sfn_rsp_if   mon_rsp,
  output int   fail_count,
  output int   pending,
  output int   results_seen,
  output int   neighbor_hits,
  output int   full_drops
);

  typedef struct {
    logic [1:0]         status;
    logic signed [15:0] tx;
    logic signed [15:0] ty;
    logic [15:0]        tag;
    logic [5:0]         index;
    logic [6:0]         count;
  } answer_t;

  // Shadow copy of the point table
  int          tab_x [DEPTH];
  int          tab_y [DEPTH];
  logic [15:0] tab_tag [DEPTH];
  int          held;

  answer_t due_answers[$];

  assign pending = due_answers.size();

  task automatic report(input string what, input longint got, input longint want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  function automatic int unsigned dist1(input int a, input int b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic answer_t point_answer(input logic [1:0] st, input bit have,
                                           input int idx);
    answer_t a;
    a.status = st;
    a.tx = '0; a.ty = '0; a.tag = '0; a.index = '0;
    if (have && idx < held) begin
      a.tx    = tab_x[idx][15:0];
      a.ty    = tab_y[idx][15:0];
      a.tag   = tab_tag[idx];
      a.index = idx[5:0];
    end
    a.count = held[6:0];
    return a;
  endfunction

  // Neighbor of an exactly hit point; returns 0 when there is none
  function automatic bit find_neighbor(input int i, input logic [2:0] dir, output int res);
    int j, best, row;
    int unsigned bestd, d;
    res = 0;
    case (dir)
      sfn_pkg::DIR_NEXT: begin
        res = (i + 1 < held) ? i + 1 : 0;
        return 1;
      end
      sfn_pkg::DIR_PREV: begin
        res = (i > 0) ? i - 1 : held - 1;
        return 1;
      end
      sfn_pkg::DIR_LEFT: begin
        if (i > 0 && tab_y[i-1] == tab_y[i]) begin
          res = i - 1;
          return 1;
        end
        return 0;
      end
      sfn_pkg::DIR_RIGHT: begin
        if (i + 1 < held && tab_y[i+1] == tab_y[i]) begin
          res = i + 1;
          return 1;
        end
        return 0;
      end
      sfn_pkg::DIR_DOWN: begin
        j = i;
        while (j < held && tab_y[j] == tab_y[i]) j++;
        if (j >= held) return 0;
        row = tab_y[j];
        best = j;
        bestd = dist1(tab_x[j], tab_x[i]);
        for (j = j + 1; j < held && tab_y[j] == row; j++) begin
          d = dist1(tab_x[j], tab_x[i]);
          if (d < bestd) begin
            bestd = d;
            best = j;
          end
        end
        res = best;
        return 1;
      end
      sfn_pkg::DIR_UP: begin
        j = i + 1;
        while (j > 0 && tab_y[j-1] == tab_y[i]) j--;
        if (j == 0) return 0;
        row = tab_y[j-1];
        best = j - 1;
        bestd = dist1(tab_x[best], tab_x[i]);
        for (j = j - 1; j > 0 && tab_y[j-1] == row; j--) begin
          d = dist1(tab_x[j-1], tab_x[i]);
          if (d < bestd) begin
            bestd = d;
            best = j - 1;
          end
        end
        res = best;
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  // Apply one request to the shadow table and work out its result
  function automatic answer_t predict_request(input logic [1:0] kind, input int px,
                                              input int py, input logic [15:0] ptag,
                                              input logic [2:0] dir);
    int pos, best, res;
    longint unsigned bestd, dd, ax, ay;
    if (kind == sfn_pkg::REQ_CLEAR) begin
      held = 0;
      return point_answer(sfn_pkg::ST_OK, 0, 0);
    end
    if (kind == sfn_pkg::REQ_ADD) begin
      if (held >= DEPTH) begin
        full_drops++;
        return point_answer(sfn_pkg::ST_FULL, 0, 0);
      end
      pos = 0;
      while (pos < held && (tab_y[pos] < py || (tab_y[pos] == py && tab_x[pos] <= px)))
        pos++;
      for (int k = held; k > pos; k--) begin
        tab_x[k]   = tab_x[k-1];
        tab_y[k]   = tab_y[k-1];
        tab_tag[k] = tab_tag[k-1];
      end
      tab_x[pos] = px;
      tab_y[pos] = py;
      tab_tag[pos] = ptag;
      held++;
      return point_answer(sfn_pkg::ST_OK, 1, pos);
    end
    if (kind == sfn_pkg::REQ_NAV) begin
      if (held == 0) return point_answer(sfn_pkg::ST_EMPTY, 0, 0);
      best = 0;
      bestd = 0;
      for (int k = 0; k < held; k++) begin
        ax = dist1(tab_x[k], px);
        ay = dist1(tab_y[k], py);
        dd = ax * ax + ay * ay;
        if (k == 0 || dd < bestd) begin
          bestd = dd;
          best = k;
        end
      end
      if (tab_x[best] == px && tab_y[best] == py) begin
        if (!find_neighbor(best, dir, res)) return point_answer(sfn_pkg::ST_NONE, 0, 0);
        neighbor_hits++;
        return point_answer(sfn_pkg::ST_OK, 1, res);
      end
      return point_answer(sfn_pkg::ST_OK, 1, best);
    end
    return point_answer(sfn_pkg::ST_OK, 0, 0);
  endfunction

  // Predict on request transfers, compare on result transfers
  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      held <= 0;
      due_answers.delete();
    end else begin
      if (mon_req.valid && mon_req.ready)
        due_answers.push_back(predict_request(mon_req.req_type, int'(mon_req.point_x),
                                              int'(mon_req.point_y), mon_req.point_tag,
                                              mon_req.direction));
      if (mon_rsp.valid && mon_rsp.ready) begin
        results_seen++;
        if (due_answers.size() == 0) begin
          $display("MISMATCH at %0t: result transfer with nothing expected", $time);
          fail_count++;
        end else begin
          want = due_answers.pop_front();
          if (mon_rsp.status !== want.status)
            report("status", mon_rsp.status, want.status);
          if (mon_rsp.target_x !== want.tx) report("target_x", mon_rsp.target_x, want.tx);
          if (mon_rsp.target_y !== want.ty) report("target_y", mon_rsp.target_y, want.ty);
          if (mon_rsp.target_tag !== want.tag)
            report("target_tag", mon_rsp.target_tag, want.tag);
          if (mon_rsp.target_index !== want.index)
            report("target_index", mon_rsp.target_index, want.index);
          if (mon_rsp.point_count !== want.count)
            report("point_count", mon_rsp.point_count, want.count);
        end
      end
    end
  end

  initial begin
    fail_count = 0;
    results_seen = 0;
    neighbor_hits = 0;
    full_drops = 0;
    held = 0;
  end

endmodule

// ----- bench/spatial_focus_navigator_core_tb.sv -----
// ----------------------------------------------------------------------------
// spatial_focus_navigator_core_tb
// Drives clear, add, navigate and reserved requests into the focus navigator, with
// random gaps and result backpressure; a checker beside the block predicts
// and compares every result.
// ----------------------------------------------------------------------------
module spatial_focus_navigator_core_tb;

  logic clk;
  logic rst_n;
  bit   calm;
  int   fail_count, pending, results_seen, neighbor_hits, full_drops;
  int   sent;
  int   held_x[$], held_y[$];

  sfn_req_if req_ch();
  sfn_rsp_if rsp_ch();

  spatial_focus_navigator_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_ch),
    .out_rsp(rsp_ch)
  );

  spatial_focus_navigator_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .mon_req      (req_ch),
    .mon_rsp      (rsp_ch),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen),
    .neighbor_hits(neighbor_hits),
    .full_drops   (full_drops)
  );

  // Clock
  always begin
    clk = 1'b0; #2;
    clk = 1'b1; #2;
  end

  // Result-side backpressure
  always @(posedge clk) begin
    rsp_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 32);
  end

  // One request transfer, then an optional idle gap
  task automatic issue(input logic [1:0] kind, input int px, input int py,
                       input logic [15:0] ptag, input logic [2:0] dir);
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= kind;
    req_ch.point_x   <= px[15:0];
    req_ch.point_y   <= py[15:0];
    req_ch.point_tag <= ptag;
    req_ch.direction <= dir;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent++;
    // mirror of held points for exact-hit cursors
    if (kind == sfn_pkg::REQ_CLEAR) begin
      held_x.delete();
      held_y.delete();
    end else if (kind == sfn_pkg::REQ_ADD && held_x.size() < sfn_pkg::DEPTH_DEF) begin
      held_x.push_back(px);
      held_y.push_back(py);
    end
    if (!calm && $urandom_range(99) < 32) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic int full_coord();
    return int'($signed(16'($urandom_range(0, 65535))));
  endfunction

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Stimulus
  initial begin
    int n, m, k, px, py, base, step;
    bit paused;
    paused = 0;
    sent = 0;
    calm = 0;
    rst_n = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.req_type = sfn_pkg::REQ_CLEAR;
    req_ch.point_x = '0;
    req_ch.point_y = '0;
    req_ch.point_tag = '0;
    req_ch.direction = sfn_pkg::DIR_NEXT;
    rsp_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, extremes, duplicates, every direction
    issue(sfn_pkg::REQ_CLEAR, 0, 0, 0, sfn_pkg::DIR_NEXT);
    issue(sfn_pkg::REQ_NAV, 0, 0, 0, sfn_pkg::DIR_NEXT);
    issue(sfn_pkg::REQ_RSVD, -1, -1, 16'hFFFF, 3'd7);
    issue(sfn_pkg::REQ_ADD, -32768, -32768, 16'hFFFF, sfn_pkg::DIR_NEXT);
    issue(sfn_pkg::REQ_ADD, 32767, 32767, 16'h0000, sfn_pkg::DIR_NEXT);
    issue(sfn_pkg::REQ_ADD, 0, 0, 16'h1234, sfn_pkg::DIR_NEXT);
    issue(sfn_pkg::REQ_ADD, 0, 0, 16'h5678, sfn_pkg::DIR_NEXT);
    issue(sfn_pkg::REQ_ADD, -5, 0, 16'h0001, sfn_pkg::DIR_NEXT);
    issue(sfn_pkg::REQ_ADD, 5, 0, 16'h0002, sfn_pkg::DIR_NEXT);
    issue(sfn_pkg::REQ_ADD, 3, 10, 16'h0003, sfn_pkg::DIR_NEXT);
    issue(sfn_pkg::REQ_ADD, -3, 10, 16'h0004, sfn_pkg::DIR_NEXT);
    issue(sfn_pkg::REQ_ADD, 0, -10, 16'h0005, sfn_pkg::DIR_NEXT);
    for (int d = 0; d < 8; d++) issue(sfn_pkg::REQ_NAV, 0, 0, 0, 3'(d));
    issue(sfn_pkg::REQ_NAV, 32767, -32768, 0, sfn_pkg::DIR_UP);
    issue(sfn_pkg::REQ_NAV, -32768, -32768, 0, sfn_pkg::DIR_PREV);
    issue(sfn_pkg::REQ_NAV, 32767, 32767, 0, sfn_pkg::DIR_NEXT);
    issue(sfn_pkg::REQ_NAV, 3, 10, 0, sfn_pkg::DIR_UP);
    issue(sfn_pkg::REQ_NAV, -3, 10, 0, sfn_pkg::DIR_DOWN);

    // Random: clear, build a table, then navigate around it, with occasional reserved requests
    while (sent < 1225) begin
      calm = (sent > 300 && sent < 450);
      if (!paused && sent > 700) begin
        wait_drained();
        paused = 1;
      end
      issue(sfn_pkg::REQ_CLEAR, full_coord(), full_coord(), 16'($urandom), 3'($urandom));
      n = ($urandom_range(9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 20);
      base = $urandom_range(0, 3) == 0 ? full_coord() : $urandom_range(0, 40) - 20;
      step = $urandom_range(1, 8);
      for (k = 0; k < n; k++) begin
        if ($urandom_range(7) == 0) begin
          px = full_coord();
          py = full_coord();
        end else begin
          px = $urandom_range(0, 16) - 8;
          py = base + step * $urandom_range(0, 4);
          if (py > 32767) py = 32767;
        end
        issue(sfn_pkg::REQ_ADD, px, py, 16'($urandom), 3'($urandom));
      end
      m = $urandom_range(5, 30);
      for (k = 0; k < m; k++) begin
        if ($urandom_range(9) == 0) begin
          issue(($urandom_range(0, 3) == 0) ? sfn_pkg::REQ_RSVD : sfn_pkg::REQ_NAV,
                full_coord(), full_coord(), 16'($urandom), 3'($urandom));
        end else if (held_x.size() > 0 && $urandom_range(99) < 75) begin
          n = $urandom_range(0, held_x.size() - 1);
          issue(sfn_pkg::REQ_NAV, held_x[n], held_y[n], 16'($urandom),
                3'($urandom_range(0, 7)));
        end else begin
          issue(sfn_pkg::REQ_NAV, $urandom_range(0, 40) - 20, base + $urandom_range(0, 40) - 20,
                16'($urandom), 3'($urandom_range(0, 7)));
        end
      end
    end

    wait_drained();
    repeat (300) @(posedge clk);
    $display("covered %0d requests, %0d results, %0d neighbor moves, %0d full drops",
             sent, results_seen, neighbor_hits, full_drops);
    if (fail_count == 0) begin
      $display("spatial_focus_navigator_core test passed");
    end else begin
      $display("spatial_focus_navigator_core test failed");
    end
    $finish;
  end

  // Timeout
  initial begin
    #10000000;
    $display("spatial_focus_navigator_core test failed");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/sfn_pkg.sv
rtl/core/sfn_if.sv
rtl/core/sfn_cell.sv
rtl/core/spatial_focus_navigator_core.sv
rtl/core/sfn_checker.sv
bench/spatial_focus_navigator_checker.sv
bench/spatial_focus_navigator_core_tb.sv
